### hdl/gf179_pkg.sv
// ----------------------------------------------------------------------------
// gf179_pkg - shared types and constants
// Opcodes, sequencer states and the type II ONB product table for GF(2^179).
// ----------------------------------------------------------------------------
package gf179_pkg;

	localparam int FieldDegree = 179;
	localparam int ModP        = 2 * FieldDegree + 1;
	localparam int TopBits     = FieldDegree - 128;
	localparam int InvChain    = 178;

	typedef logic [FieldDegree-1:0] elem_t;
	typedef logic [FieldDegree-1:0][FieldDegree-1:0] lam_tab_t;

	typedef enum logic [2:0] {
		OP_LOAD_A = 3'd0,
		OP_LOAD_B = 3'd1,
		OP_ADD    = 3'd2,
		OP_MUL    = 3'd3,
		OP_SQR    = 3'd4,
		OP_INV    = 3'd5,
		OP_TRACE  = 3'd6,
		OP_POW    = 3'd7
	} opcode_t;

	// Multiply request to the shared unit, and its reply.
	typedef struct packed {
		logic  go;
		elem_t x;
		elem_t y;
	} mul_req_t;

	typedef struct packed {
		logic  done;
		elem_t p;
	} mul_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INV_SQR,
		ST_INV_MUL1,
		ST_INV_WAIT1,
		ST_INV_MUL2,
		ST_INV_WAIT2,
		ST_POW_STEP,
		ST_POW_WAIT,
		ST_OUT
	} state_t;

	// Coefficient i sits at vector bit FieldDegree-1-i (c_0 is the MSB).
	function automatic int pow2_mod(input int i);
		int p;
		p = 1;
		for (int n = 0; n < i; n++) p = (p * 2) % ModP;
		return p;
	endfunction

	// Row i of the product table; bit (FieldDegree-1-j) holds lambda_ij.
	function automatic elem_t lam_row(input int i);
		elem_t r;
		int ei, ej, s, d, cnt;
		r  = '0;
		ei = pow2_mod(i);
		for (int j = 0; j < FieldDegree; j++) begin
			ej  = pow2_mod(j);
			s   = (ei + ej) % ModP;
			d   = (ei + ModP - ej) % ModP;
			cnt = 0;
			if (s == 1 || s == ModP - 1) cnt++;
			if (d == 1 || d == ModP - 1) cnt++;
			r[FieldDegree-1-j] = cnt[0];
		end
		return r;
	endfunction

	function automatic lam_tab_t lam_table();
		lam_tab_t t;
		for (int i = 0; i < FieldDegree; i++) t[i] = lam_row(i);
		return t;
	endfunction

	// Whole product table, worked out once at elaboration.
	localparam lam_tab_t LamTab = lam_table();

	// Squaring: coefficients move up one place, c_178 wraps to c_0.
	function automatic elem_t sqr(input elem_t x);
		return {x[0], x[FieldDegree-1:1]};
	endfunction

endpackage

### hdl/gf2_179_onb_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// gf2_179_onb_arithmetic_unit_top - GF(2^179) type II ONB arithmetic unit
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy low. Loads finish at once
// and give no item. Add and square give three result items, the first in
// the cycle after the command is taken and the other two in successive
// cycles; trace gives one item in the cycle after the command. Multiply
// runs the bit-serial multiplier once; inverse chains 10 multiplies and
// power one multiply per set exponent bit, plus one step per bit.
// busy stays high until the last item has been strobed out. Items appear
// on result_word, result_index and last_word for one cycle each with
// result_valid high, indexes 0,1,2 in successive cycles; the receiver
// cannot stall them.
// ----------------------------------------------------------------------------
module gf2_179_onb_arithmetic_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [1:0]  word_index,
	input  logic [63:0] word_value,
	output logic        result_valid,
	output logic [63:0] result_word,
	output logic [1:0]  result_index,
	output logic        last_word
);
	import gf179_pkg::*;

	localparam int KW = $clog2(FieldDegree);

	elem_t       a_q, b_q, acc_q, t_q;
	state_t      state_q, state_d;
	logic [1:0]  oidx_q;
	logic        trace_q;
	logic [2:0]  ib_q;         // inverse chain bit index
	logic [KW-1:0] k_q, sq_q;   // square count, remaining squarings
	logic [KW-1:0] n_q;         // exponent bit
	mul_req_t    req;
	mul_rsp_t    rsp;
	opcode_t     op;
	logic        take;
	logic        op_is_mul_q, tr_out_q;

	assign op   = opcode_t'(opcode);
	assign take = start && !busy;
	assign busy = (state_q != ST_IDLE);

	gf179_mul u_mul (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always_comb begin
		state_d = state_q;
		req.go  = 1'b0;
		req.x   = t_q;
		req.y   = acc_q;
		case (state_q)
			ST_IDLE: if (take) begin
				case (op)
					OP_ADD, OP_SQR, OP_TRACE: state_d = ST_OUT;
					OP_MUL: state_d = ST_POW_WAIT;
					OP_INV: state_d = ST_INV_SQR;
					OP_POW: state_d = ST_POW_STEP;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_INV_SQR:  if (sq_q == '0) state_d = ST_INV_MUL1;
			ST_INV_MUL1: begin req.go = 1'b1; state_d = ST_INV_WAIT1; end
			ST_INV_WAIT1: if (rsp.done) begin
				if (InvChain[ib_q]) state_d = ST_INV_MUL2;
				else if (ib_q == '0) state_d = ST_OUT;
				else state_d = ST_INV_SQR;
			end
			ST_INV_MUL2: begin
				req.go = 1'b1; req.x = sqr(acc_q); req.y = a_q;
				state_d = ST_INV_WAIT2;
			end
			ST_INV_WAIT2: if (rsp.done)
				state_d = (ib_q == '0) ? ST_OUT : ST_INV_SQR;
			ST_POW_STEP: begin
				if (b_q[n_q]) begin
					req.go = 1'b1; req.x = sqr(acc_q); req.y = a_q;
					state_d = ST_POW_WAIT;
				end else if (n_q == '0) state_d = ST_OUT;
			end
			ST_POW_WAIT: if (rsp.done)
				state_d = (trace_q || n_q == '0) ? ST_OUT : ST_POW_STEP;
			ST_OUT: if (oidx_q == 2'd2 || trace_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		// plain multiply: the request is issued as the command is taken
		if (state_q == ST_IDLE && take && op == OP_MUL) begin
			req.go = 1'b1; req.x = a_q; req.y = b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_q     <= '0;
			b_q     <= '0;
			oidx_q  <= '0;
			trace_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take && op == OP_LOAD_A) begin
				case (word_index)
					2'd0: a_q[FieldDegree-1:128] <= word_value[TopBits-1:0];
					2'd1: a_q[127:64] <= word_value;
					2'd2: a_q[63:0]   <= word_value;
					default: ;
				endcase
			end
			if (take && op == OP_LOAD_B) begin
				case (word_index)
					2'd0: b_q[FieldDegree-1:128] <= word_value[TopBits-1:0];
					2'd1: b_q[127:64] <= word_value;
					2'd2: b_q[63:0]   <= word_value;
					default: ;
				endcase
			end
			if (take) begin
				oidx_q  <= '0;
				trace_q <= (op == OP_TRACE) || (op == OP_MUL);
			end else if (state_q == ST_OUT) oidx_q <= oidx_q + 2'd1;
			// trace_q marks "single multiply" for mul; cleared before output
			if (state_q == ST_POW_WAIT && rsp.done && op_is_mul_q) trace_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_is_mul_q <= 1'b0;
			tr_out_q    <= 1'b0;
		end else if (take) begin
			op_is_mul_q <= (op == OP_MUL);
			tr_out_q    <= (op == OP_TRACE);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (take) begin
			case (op)
				OP_ADD: acc_q <= a_q ^ b_q;
				OP_SQR: acc_q <= sqr(a_q);
				OP_TRACE: acc_q <= {{(FieldDegree-1){1'b0}}, ^a_q};
				OP_INV: begin
					acc_q <= a_q; t_q <= sqr(a_q);
					ib_q <= 3'd6; k_q <= KW'(1); sq_q <= '0;
				end
				OP_POW: begin
					acc_q <= '1; n_q <= KW'(FieldDegree - 1);
				end
				default: ;
			endcase
		end else begin
			case (state_q)
				ST_INV_SQR: if (sq_q != '0) begin
					t_q <= sqr(t_q); sq_q <= sq_q - 1'b1;
				end
				ST_INV_WAIT1: if (rsp.done) begin
					acc_q <= rsp.p;
					k_q   <= {k_q[KW-2:0], 1'b0};
					if (!InvChain[ib_q]) begin
						ib_q <= ib_q - 1'b1;
						t_q  <= sqr(rsp.p);
						sq_q <= {k_q[KW-2:0], 1'b0} - 1'b1;
						if (ib_q == '0) acc_q <= sqr(rsp.p);
					end
				end
				ST_INV_WAIT2: if (rsp.done) begin
					acc_q <= rsp.p;
					k_q   <= k_q + 1'b1;
					ib_q  <= ib_q - 1'b1;
					t_q   <= sqr(rsp.p);
					sq_q  <= k_q;
					if (ib_q == '0) acc_q <= sqr(rsp.p);
				end
				ST_POW_STEP: begin
					if (!b_q[n_q]) begin
						acc_q <= sqr(acc_q);
						n_q   <= n_q - 1'b1;
					end
				end
				ST_POW_WAIT: if (rsp.done) begin
					acc_q <= rsp.p;
					if (!op_is_mul_q) n_q <= n_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign result_valid = (state_q == ST_OUT);
	assign result_index = tr_out_q ? 2'd0 : oidx_q;
	assign last_word    = tr_out_q || (oidx_q == 2'd2);
	always_comb begin
		case (oidx_q)
			2'd0:    result_word = tr_out_q ? {63'd0, acc_q[0]}
			                      : {{(128+64-FieldDegree){1'b0}}, acc_q[FieldDegree-1:128]};
			2'd1:    result_word = acc_q[127:64];
			default: result_word = acc_q[63:0];
		endcase
	end

endmodule

### hdl/gf179_mul.sv
// ----------------------------------------------------------------------------
// gf179_mul - Massey-Omura bit-serial multiplier
// One product coefficient a cycle while busy; a new request is taken only when idle.
// ----------------------------------------------------------------------------
module gf179_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gf179_pkg::mul_req_t  req,
	output gf179_pkg::mul_rsp_t  rsp
);
	import gf179_pkg::*;

	localparam int CntW = $clog2(FieldDegree + 1);

	elem_t            rl_q, rr_q, res_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q, done_q;
	logic             coef;

	// c_k = sum_i a_i * (lambda_i . b)
	always_comb begin
		coef = 1'b0;
		for (int i = 0; i < FieldDegree; i++)
			coef ^= rl_q[FieldDegree-1-i] & (^(LamTab[i] & rr_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CntW'(FieldDegree - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go && !busy_q) begin
			rl_q  <= req.x;
			rr_q  <= req.y;
			res_q <= '0;
		end else if (busy_q) begin
			res_q <= {res_q[FieldDegree-2:0], coef};
			rl_q  <= {rl_q[FieldDegree-2:0], rl_q[FieldDegree-1]};
			rr_q  <= {rr_q[FieldDegree-2:0], rr_q[FieldDegree-1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = res_q;

endmodule

### hdl/gf179_checker.sv
// ----------------------------------------------------------------------------
// gf179_checker - port-level checks
// Result sequencing and busy behaviour seen from the ports.
// ----------------------------------------------------------------------------
module gf179_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        result_valid,
	input logic [1:0]  result_index,
	input logic        last_word
);
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("item while not busy");

	a_next_idx: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_word |=> result_valid &&
		result_index == $past(result_index) + 2'd1) else $error("index order");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_word |=> !busy) else $error("busy after last");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_index != 2'd3) else $error("bad index");
endmodule

bind gf2_179_onb_arithmetic_unit_top gf179_checker u_chk (
	.clk(clk), .arst_n(arst_n), .busy(busy),
	.result_valid(result_valid), .result_index(result_index),
	.last_word(last_word)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for the GF(2^179) type II ONB arithmetic unit
// Drives load, add, multiply, square, inverse, trace and power commands,
// predicts every result word with a behavioural model of normal-basis
// arithmetic and compares each strobed item against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gf179_pkg::*;

	localparam int NDEG      = 179;
	localparam int IDLE_LIM  = 200000; // power with all exponent bits set, plus margin
	localparam int N_RANDOM  = 376;

	typedef struct {
		logic [63:0] word;
		logic [1:0]  index;
		logic        last;
	} result_item_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  opcode;
	logic [1:0]  word_index;
	logic [63:0] word_value;
	logic        result_valid;
	logic [63:0] result_word;
	logic [1:0]  result_index;
	logic        last_word;

	// predictor state: operands as 179-bit vectors, c_0 at the MSB
	logic [NDEG-1:0] mdl_a, mdl_b;
	logic [NDEG-1:0] prod_row [NDEG];

	result_item_t expected_items [$];
	int mismatches;
	int idle_cycles;
	bit timed_out;

	gf2_179_onb_arithmetic_unit_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.word_index   (word_index),
		.word_value   (word_value),
		.result_valid (result_valid),
		.result_word  (result_word),
		.result_index (result_index),
		.last_word    (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---- normal-basis arithmetic -------------------------------------------

	// Product table: lambda_ij is 1 when an odd number of 2^i +- 2^j is +-1 mod 359.
	function automatic void build_products();
		int pw [NDEG];
		int s, d, cnt, p;
		p = 1;
		for (int i = 0; i < NDEG; i++) begin
			pw[i] = p;
			p = (p * 2) % (2 * NDEG + 1);
		end
		for (int i = 0; i < NDEG; i++) begin
			prod_row[i] = '0;
			for (int j = 0; j < NDEG; j++) begin
				s = (pw[i] + pw[j]) % (2 * NDEG + 1);
				d = (pw[i] + 2 * NDEG + 1 - pw[j]) % (2 * NDEG + 1);
				cnt = 0;
				if (s == 1 || s == 2 * NDEG) cnt++;
				if (d == 1 || d == 2 * NDEG) cnt++;
				prod_row[i][NDEG-1-j] = cnt[0];
			end
		end
	endfunction

	// Frobenius: c_i moves to c_(i+1), c_178 wraps to c_0 (rotate right).
	function automatic logic [NDEG-1:0] frob(input logic [NDEG-1:0] x);
		return {x[0], x[NDEG-1:1]};
	endfunction

	// Massey-Omura: c_k uses both operands rotated k places towards c_0.
	function automatic logic [NDEG-1:0] onb_mul(input logic [NDEG-1:0] x,
			input logic [NDEG-1:0] y);
		logic [NDEG-1:0] rx, ry, res;
		logic bitv;
		rx  = x;
		ry  = y;
		res = '0;
		for (int k = 0; k < NDEG; k++) begin
			bitv = 1'b0;
			for (int i = 0; i < NDEG; i++)
				if (rx[NDEG-1-i]) bitv ^= ^(prod_row[i] & ry);
			res[NDEG-1-k] = bitv;
			rx = {rx[NDEG-2:0], rx[NDEG-1]};
			ry = {ry[NDEG-2:0], ry[NDEG-1]};
		end
		return res;
	endfunction

	// Itoh-Tsujii over the addition chain for 178, final square gives a^-1.
	function automatic logic [NDEG-1:0] onb_inv(input logic [NDEG-1:0] x);
		logic [NDEG-1:0] acc, t;
		int k;
		acc = x;
		k   = 1;
		for (int i = 6; i >= 0; i--) begin
			t = acc;
			for (int j = 0; j < k; j++) t = frob(t);
			acc = onb_mul(t, acc);
			k = k * 2;
			if ((178 >> i) & 1) begin
				acc = onb_mul(frob(acc), x);
				k++;
			end
		end
		return frob(acc);
	endfunction

	// Exponent bit n is bit n of the 179-bit integer held in operand b.
	function automatic logic [NDEG-1:0] onb_pow(input logic [NDEG-1:0] x,
			input logic [NDEG-1:0] e);
		logic [NDEG-1:0] c;
		c = '1;
		for (int n = NDEG - 1; n >= 0; n--) begin
			c = frob(c);
			if (e[n]) c = onb_mul(c, x);
		end
		return c;
	endfunction

	// Work out the result items one command causes and queue them.
	function automatic void predict_command(input opcode_t op, input logic [1:0] idx,
			input logic [63:0] val);
		logic [NDEG-1:0] r;
		logic [191:0] wide;
		result_item_t it;
		case (op)
			OP_LOAD_A, OP_LOAD_B: begin
				if (idx != 2'd3) begin
					wide = {13'd0, (op == OP_LOAD_A) ? mdl_a : mdl_b};
					wide[(2 - idx) * 64 +: 64] = val;
					if (op == OP_LOAD_A) mdl_a = wide[NDEG-1:0];
					else mdl_b = wide[NDEG-1:0];
				end
				return;
			end
			OP_TRACE: begin
				it.word  = {63'd0, ^mdl_a};
				it.index = 2'd0;
				it.last  = 1'b1;
				expected_items.push_back(it);
				return;
			end
			OP_ADD: r = mdl_a ^ mdl_b;
			OP_MUL: r = onb_mul(mdl_a, mdl_b);
			OP_SQR: r = frob(mdl_a);
			OP_INV: r = onb_inv(mdl_a);
			default: r = onb_pow(mdl_a, mdl_b);
		endcase
		wide = {13'd0, r};
		for (int i = 0; i < 3; i++) begin
			it.word  = wide[(2 - i) * 64 +: 64];
			it.index = i[1:0];
			it.last  = (i == 2);
			expected_items.push_back(it);
		end
	endfunction

	// ---- driving ------------------------------------------------------------

	// Present one item at the falling edge, hold until taken with busy low.
	task automatic send_item(input opcode_t op, input logic [1:0] idx,
			input logic [63:0] val);
		@(negedge clk);
		start      <= 1'b1;
		opcode     <= op;
		word_index <= idx;
		word_value <= val;
		do @(posedge clk); while (busy);
		predict_command(op, idx, val);
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic load_pair(input logic [NDEG-1:0] x, input logic [NDEG-1:0] y);
		logic [191:0] wx, wy;
		wx = {13'd0, x};
		wy = {13'd0, y};
		for (int i = 0; i < 3; i++) begin
			send_item(OP_LOAD_A, i[1:0], wx[(2 - i) * 64 +: 64]);
			send_item(OP_LOAD_B, i[1:0], wy[(2 - i) * 64 +: 64]);
		end
	endtask

	task automatic drain_results();
		while (expected_items.size() != 0 && !timed_out) @(posedge clk);
	endtask

	function automatic logic [NDEG-1:0] rand_elem();
		logic [191:0] w;
		w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return w[NDEG-1:0];
	endfunction

	// Small weighted exponent: a few bits set keeps power runs short.
	function automatic logic [NDEG-1:0] sparse_exp();
		logic [NDEG-1:0] e;
		e = '0;
		repeat ($urandom_range(0, 4)) e[$urandom_range(0, NDEG - 1)] = 1'b1;
		return e;
	endfunction

	// Loads with full-width data, including the masked upper bits and index three, then trace, add and square.
	task automatic test_load_extremes();
		send_item(OP_LOAD_A, 2'd0, '1);
		send_item(OP_LOAD_A, 2'd1, '1);
		send_item(OP_LOAD_A, 2'd2, '1);
		send_item(OP_LOAD_B, 2'd3, '1);
		send_item(OP_TRACE, 2'd0, '0);
		send_item(OP_ADD, 2'd1, '1);
		send_item(OP_SQR, 2'd2, '0);
	endtask

	// Zero operands: inverse of zero, zero exponent gives the unit element, product and trace of zero.
	task automatic test_zero_cases();
		load_pair('0, '0);
		send_item(OP_INV, 2'd0, '0);
		send_item(OP_POW, 2'd0, '0);
		send_item(OP_MUL, 2'd0, '0);
		send_item(OP_TRACE, 2'd0, '0);
	endtask

	// Every operation on random operands, unit element as a operand too.
	task automatic test_each_operation();
		load_pair('1, rand_elem());
		send_item(OP_MUL, 2'd0, '0);
		send_item(OP_INV, 2'd0, '0);
		load_pair(rand_elem(), sparse_exp());
		for (int op = OP_ADD; op <= OP_POW; op++)
			send_item(opcode_t'(op), 2'd0, '0);
		load_pair(rand_elem(), {NDEG{1'b1}}); // every exponent bit set, once
		send_item(OP_POW, 2'd0, '0);
	endtask

	// Random bursts, mostly loads followed by a cheap or mid-cost operation.
	task automatic test_random_traffic();
		int burst;
		opcode_t op;
		int n;
		n = 0;
		while (n < N_RANDOM) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: op = OP_LOAD_A;
					3, 4:    op = OP_LOAD_B;
					5:       op = OP_ADD;
					6:       op = ($urandom_range(0, 3) == 0) ? OP_MUL : OP_SQR;
					7:       op = OP_TRACE;
					8:       op = ($urandom_range(0, 7) == 0) ? OP_INV : OP_SQR;
					default: op = ($urandom_range(0, 5) == 0) ? OP_POW : OP_ADD;
				endcase
				// power with a dense exponent would be too slow: sparsify b first
				if (op == OP_POW) begin
					load_pair(mdl_a, sparse_exp());
					n += 6;
				end
				send_item(op, 2'($urandom_range(0, 3)), {$urandom, $urandom});
			end
			if ($urandom_range(0, 5) == 0) drain_results();
			else repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	endtask

	// ---- checking -----------------------------------------------------------

	always @(posedge clk) begin
		result_item_t ex;
		if (arst_n && result_valid) begin
			if (expected_items.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: word %h index %0d last %0b",
						result_word, result_index, last_word);
			end else begin
				ex = expected_items.pop_front();
				if (ex.word !== result_word || ex.index !== result_index ||
						ex.last !== last_word) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
							ex.word, ex.index, ex.last,
							result_word, result_index, last_word);
				end
			end
		end
	end

	// Watchdog: cycles with neither a command taken nor a result strobed.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIM && !timed_out) begin
			timed_out <= 1'b1;
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		mismatches  = 0;
		idle_cycles = 0;
		timed_out   = 1'b0;
		start       = 1'b0;
		opcode      = OP_LOAD_A;
		word_index  = '0;
		word_value  = '0;
		mdl_a       = '0;
		mdl_b       = '0;
		arst_n      = 1'b0;
		build_products();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_load_extremes();
		test_zero_cases();
		drain_results(); // sender holds off until all results are back
		test_each_operation();
		test_random_traffic();

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_items.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
